FILE: src/host_descriptor_table_core_assert.svh
// assertion macros for the host descriptor table
`ifndef HOST_DESCRIPTOR_TABLE_CORE_ASSERT_SVH
`define HOST_DESCRIPTOR_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HDT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hdt assertion failed");
// next-cycle implication
`define HDT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hdt assertion failed");
`else
`define HDT_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define HDT_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/hdt_pkg.sv
package hdt_pkg;

    // fixed field widths
    localparam int MAC_W       = 48;
    localparam int IP_W        = 32;
    localparam int PORT_MASK_W = 32;
    localparam int KIND_W      = 3;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT   = 3'd0,
        KIND_REGISTER = 3'd1,
        KIND_DELETE   = 3'd2,
        KIND_SET_IP   = 3'd3,
        KIND_SET_MASK = 3'd4,
        KIND_PRESENT  = 3'd5,
        KIND_CHECK_IP = 3'd6,
        KIND_SEARCH   = 3'd7
    } t_kind;

endpackage

FILE: src/hdt_entry_ram.sv
module hdt_entry_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 112,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/hdt_scan_ctrl.sv
`include "host_descriptor_table_core_assert.svh"

module hdt_scan_ctrl #(
    parameter int HOST_ENTRIES = 64,
    parameter int MASK_W       = 32,
    parameter int IDX_W        = 6,
    parameter int CNT_W        = 7,
    parameter int ENT_W        = 112
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request side
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [hdt_pkg::KIND_W-1:0]      i_kind,
    input  logic [hdt_pkg::MAC_W-1:0]       i_mac_key,
    input  logic [hdt_pkg::IP_W-1:0]        i_ip_value,
    input  logic [hdt_pkg::PORT_MASK_W-1:0] i_category_mask,
    // result side
    output logic                            o_done,
    output logic                            o_hit,
    output logic                            o_full_flag,
    output logic [hdt_pkg::MAC_W-1:0]       o_found_mac,
    output logic [hdt_pkg::PORT_MASK_W-1:0] o_found_mask,
    output logic [CNT_W-1:0]                o_entry_count,
    // entry memory
    output logic                            o_wr_en,
    output logic [IDX_W-1:0]                o_wr_addr,
    output logic [ENT_W-1:0]                o_wr_data,
    output logic                            o_rd_en,
    output logic [IDX_W-1:0]                o_rd_addr,
    input  logic [ENT_W-1:0]                i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_APPEND = 3'b010,
        S_SCAN   = 3'b100
    } t_state;

    t_state                       r_state;
    hdt_pkg::t_kind               r_kind;
    logic [hdt_pkg::MAC_W-1:0]    r_key;
    logic [hdt_pkg::IP_W-1:0]     r_ip;
    logic [MASK_W-1:0]            r_mask;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_rd_cnt;
    logic [CNT_W-1:0]             r_wr_cnt;
    logic [IDX_W-1:0]             r_chk_idx;
    logic                         r_pend;
    logic                         r_hit;
    logic                         r_found;
    logic [hdt_pkg::MAC_W-1:0]    r_fmac;
    logic [MASK_W-1:0]            r_fmask;
    logic                         r_out_valid;
    logic                         r_out_hit;
    logic                         r_out_full;
    logic [hdt_pkg::MAC_W-1:0]    r_out_mac;
    logic [MASK_W-1:0]            r_out_mask;
    logic [CNT_W-1:0]             r_out_count;

    logic                         full_now;
    logic                         scan_issue;
    logic                         key_match;
    logic                         ip_match;
    logic [hdt_pkg::MAC_W-1:0]    rd_key;
    logic [hdt_pkg::IP_W-1:0]     rd_ip;
    logic [MASK_W-1:0]            rd_mask;

    // unpack the entry read last cycle
    assign rd_key    = i_rd_data[ENT_W-1 -: hdt_pkg::MAC_W];
    assign rd_ip     = i_rd_data[MASK_W +: hdt_pkg::IP_W];
    assign rd_mask   = i_rd_data[MASK_W-1:0];
    assign key_match = (rd_key == r_key);
    assign ip_match  = (rd_ip == r_ip);

    assign full_now   = (r_count == CNT_W'(HOST_ENTRIES));
    assign scan_issue = (r_state == S_SCAN) && (r_rd_cnt != r_count);

    // read port walks the valid entries in order
    assign o_rd_en   = scan_issue;
    assign o_rd_addr = r_rd_cnt[IDX_W-1:0];

    // write port: append, compaction or in-place rewrite
    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_addr = r_count[IDX_W-1:0];
        o_wr_data = {r_key, r_ip, {MASK_W{1'b0}}};
        if (r_state == S_APPEND) begin
            o_wr_en = !full_now;
            if (r_kind == hdt_pkg::KIND_REGISTER) begin
                o_wr_data = {r_key, {hdt_pkg::IP_W{1'b0}}, r_mask};
            end
        end else if ((r_state == S_SCAN) && r_pend) begin
            case (r_kind)
                hdt_pkg::KIND_DELETE: begin
                    o_wr_en   = !key_match;
                    o_wr_addr = r_wr_cnt[IDX_W-1:0];
                    o_wr_data = i_rd_data;
                end
                hdt_pkg::KIND_SET_IP: begin
                    o_wr_en   = key_match;
                    o_wr_addr = r_chk_idx;
                    o_wr_data = {rd_key, r_ip, rd_mask};
                end
                hdt_pkg::KIND_SET_MASK: begin
                    o_wr_en   = key_match;
                    o_wr_addr = r_chk_idx;
                    o_wr_data = {rd_key, rd_ip, r_mask};
                end
                default: begin
                    o_wr_en = 1'b0;
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_kind   <= hdt_pkg::t_kind'(i_kind);
                        r_key    <= i_mac_key;
                        r_ip     <= i_ip_value;
                        r_mask   <= i_category_mask[MASK_W-1:0];
                        r_hit    <= 1'b0;
                        r_found  <= 1'b0;
                        r_fmac   <= '0;
                        r_fmask  <= '0;
                        r_rd_cnt <= '0;
                        r_wr_cnt <= '0;
                        r_pend   <= 1'b0;
                        if ((i_kind == hdt_pkg::KIND_INSERT) ||
                            (i_kind == hdt_pkg::KIND_REGISTER)) begin
                            r_state <= S_APPEND;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_APPEND: begin
                    // full insert wipes the table, full register is refused
                    r_out_valid <= 1'b1;
                    r_out_hit   <= 1'b0;
                    r_out_full  <= full_now;
                    r_out_mac   <= '0;
                    r_out_mask  <= '0;
                    if (full_now) begin
                        if (r_kind == hdt_pkg::KIND_INSERT) begin
                            r_count     <= '0;
                            r_out_count <= '0;
                        end else begin
                            r_out_count <= r_count;
                        end
                    end else begin
                        r_count     <= r_count + 1'b1;
                        r_out_count <= r_count + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    // issue stage
                    r_pend <= scan_issue;
                    if (scan_issue) begin
                        r_rd_cnt  <= r_rd_cnt + 1'b1;
                        r_chk_idx <= r_rd_cnt[IDX_W-1:0];
                    end
                    // compare stage on the returned entry
                    if (r_pend) begin
                        case (r_kind) inside
                            hdt_pkg::KIND_DELETE: begin
                                if (key_match) begin
                                    r_hit <= 1'b1;
                                end else begin
                                    r_wr_cnt <= r_wr_cnt + 1'b1;
                                end
                            end
                            hdt_pkg::KIND_SET_IP, hdt_pkg::KIND_SET_MASK,
                            hdt_pkg::KIND_PRESENT: begin
                                if (key_match) begin
                                    r_hit <= 1'b1;
                                end
                            end
                            hdt_pkg::KIND_CHECK_IP: begin
                                if (key_match && !r_found) begin
                                    r_found <= 1'b1;
                                    r_hit   <= ip_match;
                                end
                            end
                            hdt_pkg::KIND_SEARCH: begin
                                if (ip_match && !r_found) begin
                                    r_found <= 1'b1;
                                    r_hit   <= 1'b1;
                                    r_fmac  <= rd_key;
                                    r_fmask <= rd_mask;
                                end
                            end
                            default: begin
                                r_hit <= r_hit;
                            end
                        endcase
                    end
                    // all entries read and compared
                    if (!scan_issue && !r_pend) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_hit;
                        r_out_full  <= 1'b0;
                        r_out_mac   <= r_fmac;
                        r_out_mask  <= r_fmask;
                        if (r_kind == hdt_pkg::KIND_DELETE) begin
                            r_count     <= r_wr_cnt;
                            r_out_count <= r_wr_cnt;
                        end else begin
                            r_out_count <= r_count;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_full_flag   = r_out_full;
    assign o_found_mac   = r_out_mac;
    assign o_found_mask  = hdt_pkg::PORT_MASK_W'(r_out_mask);
    assign o_entry_count = r_out_count;

    // table never grows past its depth
    `HDT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(HOST_ENTRIES))
    // result word only appears once the sequencer is back at rest
    `HDT_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_out_valid, r_state == S_IDLE)
    // compaction writes never overtake the entry being compared
    `HDT_ASSERT_IMP(a_compact_behind, i_clk, i_rst_n,
        (r_state == S_SCAN) && r_pend && (r_kind == hdt_pkg::KIND_DELETE),
        r_wr_cnt <= CNT_W'(r_chk_idx))
    // an accepted request makes the block busy
    `HDT_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, r_state != S_IDLE)

endmodule

FILE: src/host_descriptor_table_core.sv
// host descriptor table: ordered host entries in one single-port-read entry memory
// result: insert and register show their result word straight from the append state;
//   every other request walks the N valid entries in the scan state and then shows it
// requests: a new request is taken at the edge that ends its predecessor's strobe, so requests
//   never overlap; the scan makes one memory read per cycle
// reset: synchronous, clears the entry count and control; memory contents stay, no clearing pass
module host_descriptor_table_core #(
    parameter int HOST_ENTRIES  = 64,
    parameter int CATEGORY_BITS = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic [hdt_pkg::KIND_W-1:0]                  i_kind,
    input  logic [hdt_pkg::MAC_W-1:0]                   i_mac_key,
    input  logic [hdt_pkg::IP_W-1:0]                    i_ip_value,
    input  logic [hdt_pkg::PORT_MASK_W-1:0]             i_category_mask,
    output logic                                        o_done,
    output logic                                        o_hit,
    output logic                                        o_full_flag,
    output logic [hdt_pkg::MAC_W-1:0]                   o_found_mac,
    output logic [hdt_pkg::PORT_MASK_W-1:0]             o_found_mask,
    output logic [$clog2(HOST_ENTRIES+1)-1:0]           o_entry_count
);

    localparam int IDX_W  = $clog2(HOST_ENTRIES);
    localparam int CNT_W  = $clog2(HOST_ENTRIES + 1);
    localparam int MASK_W = (CATEGORY_BITS >= hdt_pkg::PORT_MASK_W) ?
                            hdt_pkg::PORT_MASK_W : CATEGORY_BITS;
    localparam int ENT_W  = hdt_pkg::MAC_W + hdt_pkg::IP_W + MASK_W;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;

    // entry memory: key, address and category mask per host
    hdt_entry_ram #(
        .DEPTH  (HOST_ENTRIES),
        .WIDTH  (ENT_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // request sequencer and scan datapath
    hdt_scan_ctrl #(
        .HOST_ENTRIES (HOST_ENTRIES),
        .MASK_W       (MASK_W),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W),
        .ENT_W        (ENT_W)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_kind          (i_kind),
        .i_mac_key       (i_mac_key),
        .i_ip_value      (i_ip_value),
        .i_category_mask (i_category_mask),
        .o_done          (o_done),
        .o_hit           (o_hit),
        .o_full_flag     (o_full_flag),
        .o_found_mac     (o_found_mac),
        .o_found_mask    (o_found_mask),
        .o_entry_count   (o_entry_count),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data)
    );

endmodule
